/* sv/brb_pkg.sv */
`default_nettype none

package brb_pkg;

  localparam int CNT_W   = 13;
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int QCW     = $clog2(QDEPTH + 1);

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REJECTED  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_TOO_LARGE = 2'd3;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_BIG   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       data_byte;
    logic             run_first;
    logic [CNT_W-1:0] count;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             last;
    logic [1:0]       status;
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] free_count;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data_byte;
    logic             run_first;
    logic [CNT_W-1:0] count;
  } qent_t;

endpackage

`default_nettype wire

/* sv/byte_ring_buffer_burst.sv */
`default_nettype none

// Byte circular FIFO over CAPACITY bytes in one single-port-write, single-port-read
// memory. A front end takes one item per cycle while it has room into a four-entry
// command queue, turning oversized pop requests into a status and dropping empty
// pops and the unused command; the back end executes the queue in order. A pop
// of N bytes in the back end first loads the count, then sends one byte per cycle
// through the memory read port while the output is not stalled. The byte store is
// not cleared at reset; only held bytes are ever read, so the block is ready right
// after reset.
module byte_ring_buffer_burst import brb_pkg::*; #(
  parameter int CAPACITY = 4096,
  parameter int MAX_POP  = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  logic  q_valid;
  logic  q_ready;
  qent_t q_entry;

  brb_front #(
    .MAX_POP (MAX_POP)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_entry  (q_entry)
  );

  brb_back #(
    .CAPACITY (CAPACITY),
    .MAX_POP  (MAX_POP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* sv/brb_front.sv */
`default_nettype none

module brb_front import brb_pkg::*; #(
  parameter int MAX_POP = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          q_valid,
  input  wire logic     q_ready,
  output qent_t         q_entry
);

  qent_t            q_mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   fill_r, fill_nxt;
  qent_t            ent;
  logic             keep;
  logic             push_q, pop_q;

  // classify: pops of zero bytes and the unused command leave no trace
  always_comb begin
    ent.data_byte = in_data.data_byte;
    ent.run_first = in_data.run_first;
    ent.count     = in_data.count;
    ent.op        = OP_PUSH;
    keep          = 1'b1;
    unique case (in_data.cmd)
      CMD_PUSH: ent.op = OP_PUSH;
      CMD_POP: begin
        if (in_data.count > CNT_W'(MAX_POP)) begin
          ent.op = OP_BIG;
        end else begin
          ent.op = OP_POP;
          keep   = (in_data.count != '0);
        end
      end
      CMD_CLEAR: ent.op = OP_CLEAR;
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = (fill_r != QCW'(QDEPTH));
  assign q_valid  = (fill_r != '0);
  assign q_entry  = q_mem_r[rd_ptr_r];
  assign push_q   = in_valid && in_ready && keep;
  assign pop_q    = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push_q ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_q  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r + QCW'(push_q) - QCW'(pop_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_q) begin
      q_mem_r[wr_ptr_r] <= ent;
    end
  end

endmodule

`default_nettype wire

/* sv/brb_back.sv */
`default_nettype none

module brb_back import brb_pkg::*; #(
  parameter int CAPACITY = 4096,
  parameter int MAX_POP  = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire qent_t q_entry,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_data
);

  localparam int PW  = $clog2(CAPACITY);
  localparam int HW  = $clog2(CAPACITY + 1);
  localparam int CW  = (HW > CNT_W) ? HW : CNT_W;
  localparam int PRW = $clog2(MAX_POP + 1);

  logic [7:0]       mem [CAPACITY];
  logic [7:0]       rd_data_r;

  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [HW-1:0]    held_r, held_nxt;
  logic             dropping_r, dropping_nxt;
  logic [PRW-1:0]   pop_rem_r, pop_rem_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             is_byte_r;
  logic             last_r;
  logic [1:0]       status_r;
  logic [CNT_W-1:0] used_r, free_r;

  logic             adv;
  logic             emit, emit_byte, emit_last;
  logic [1:0]       emit_status;
  logic             rd_en, wr_en;
  logic [HW-1:0]    room;
  logic [HW-1:0]    free_nxt;

  function automatic logic [PW-1:0] step_ptr(input logic [PW-1:0] p);
    step_ptr = (p == PW'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  assign adv  = !out_valid_r || out_ready;
  assign room = HW'(CAPACITY) - held_r;

  always_comb begin
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    held_nxt     = held_r;
    dropping_nxt = dropping_r;
    pop_rem_nxt  = pop_rem_r;
    emit         = 1'b0;
    emit_byte    = 1'b0;
    emit_last    = 1'b1;
    emit_status  = ST_OK;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    q_ready      = 1'b0;
    if (pop_rem_r != '0) begin
      // pop in progress: one byte per transfer
      if (adv) begin
        emit        = 1'b1;
        emit_byte   = 1'b1;
        emit_last   = (pop_rem_r == PRW'(1));
        rd_en       = 1'b1;
        rd_ptr_nxt  = step_ptr(rd_ptr_r);
        held_nxt    = held_r - 1'b1;
        pop_rem_nxt = pop_rem_r - 1'b1;
      end
    end else if (q_valid) begin
      unique case (q_entry.op)
        OP_PUSH: begin
          if (q_entry.run_first && (CW'(q_entry.count) > CW'(room))) begin
            q_ready  = adv;
            if (adv) begin
              dropping_nxt = 1'b1;
              emit         = 1'b1;
              emit_status  = ST_REJECTED;
            end
          end else if (!q_entry.run_first && dropping_r) begin
            q_ready = 1'b1;
          end else if (room == '0) begin
            q_ready  = adv;
            if (adv) begin
              dropping_nxt = 1'b0;
              emit         = 1'b1;
              emit_status  = ST_REJECTED;
            end
          end else begin
            q_ready      = 1'b1;
            dropping_nxt = 1'b0;
            wr_en        = 1'b1;
            wr_ptr_nxt   = step_ptr(wr_ptr_r);
            held_nxt     = held_r + 1'b1;
          end
        end
        OP_POP: begin
          if (CW'(q_entry.count) > CW'(held_r)) begin
            q_ready  = adv;
            if (adv) begin
              emit        = 1'b1;
              emit_status = ST_UNDERFLOW;
            end
          end else begin
            q_ready     = 1'b1;
            pop_rem_nxt = PRW'(q_entry.count);
          end
        end
        OP_CLEAR: begin
          q_ready      = 1'b1;
          rd_ptr_nxt   = '0;
          wr_ptr_nxt   = '0;
          held_nxt     = '0;
          dropping_nxt = 1'b0;
        end
        OP_BIG: begin
          q_ready  = adv;
          if (adv) begin
            emit        = 1'b1;
            emit_status = ST_TOO_LARGE;
          end
        end
        default: q_ready = 1'b1;
      endcase
    end
    out_valid_nxt = adv ? emit : out_valid_r;
    free_nxt      = HW'(CAPACITY) - held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      held_r      <= '0;
      dropping_r  <= 1'b0;
      pop_rem_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      held_r      <= held_nxt;
      dropping_r  <= dropping_nxt;
      pop_rem_r   <= pop_rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register, loaded only when the output slot moves
  always_ff @(posedge clk) begin
    if (adv && emit) begin
      is_byte_r <= emit_byte;
      last_r    <= emit_last;
      status_r  <= emit_status;
      used_r    <= CNT_W'(held_nxt);
      free_r    <= CNT_W'(free_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= q_entry.data_byte;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  // status results never shift a stored byte out
  assign out_valid           = out_valid_r;
  assign out_data.out_byte   = is_byte_r ? rd_data_r : 8'd0;
  assign out_data.last       = last_r;
  assign out_data.status     = status_r;
  assign out_data.used_count = used_r;
  assign out_data.free_count = free_r;

endmodule

`default_nettype wire

/* sv/brb_checker.sv */
`default_nettype none

module brb_checker import brb_pkg::*; #(
  parameter int CAPACITY = 4096
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  logic [CNT_W-1:0] count_sum;
  assign count_sum = out_data.used_count + out_data.free_count;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input transfer changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> count_sum == CNT_W'(CAPACITY))
    else $error("used and free counts disagree with capacity");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.last && out_data.out_byte == 8'd0)
    else $error("status result not a lone zero-byte transfer");

  a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_ready))
    else $error("input ready unknown");

endmodule

bind byte_ring_buffer_burst brb_checker #(
  .CAPACITY (CAPACITY)
) u_brb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
